// ===== rtl/core/lzmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzmd_pkg
// Shared types and constants of the marker-token decompressor: history
// geometry, token codes, result status codes and controller/datapath links.
// ----------------------------------------------------------------------------
package lzmd_pkg;

    // History store geometry
    localparam int HISTORY_DEPTH = 2048;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
    // Width for source address arithmetic (holds wp + depth)
    localparam int CALC_W        = HIST_AW + 2;

    // Reach and counting
    localparam int          DIST_W    = 12;
    localparam int          LEN_W     = 6;
    localparam logic [11:0] MAX_REACH = 12'd2048;

    // Token codes
    localparam logic [7:0] MARK_BYTE = 8'h03;
    localparam logic [7:0] ZERO_BYTE = 8'h00;
    localparam logic [2:0] DIST_HI_MASK = 3'h7;
    localparam logic [LEN_W-1:0] LEN_BIAS = 6'd2;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_TRUNC_MARK  = 2'd1,
        ST_TRUNC_TOKEN = 2'd2,
        ST_DIST_FAR    = 2'd3
    } status_t;

    // Source of a stored and emitted byte
    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_MARK,
        SRC_HIST
    } src_t;

    // Controller sequencing states
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_COPY_RD,
        CS_COPY_WR
    } ctrl_state_t;

    // Token parse phase
    typedef enum logic [1:0] {
        PH_LIT,
        PH_MARK,
        PH_MID
    } phase_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    store;       // write byte to history and output register
        src_t    src;
        logic    emit_err;    // load an error result
        status_t err_code;
        logic    hold_mid;    // capture middle byte
        logic    start_copy;  // latch length and distance
        logic    copy_rd;     // issue history read
        logic    clear;       // end of stream: reset pointers
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_marker;
        logic is_zero;
        logic too_far;
        logic copy_last;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/core/lz77_marker_token_decompressor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_marker_token_decompressor
// Marker-token LZ77 decompressor with a 2048-byte history window.
// ----------------------------------------------------------------------------
// A literal result appears in the cycle after its item is accepted.
// Literals and token bytes are taken while idle and the output is free; a
//   match copies 2..33 bytes, each a history RAM read, then write and emit.
// Reset: aresetn (synchronous, active low) clears the parse state, pointers
//   and output valid; history contents are undefined until written.
// ----------------------------------------------------------------------------
module lz77_marker_token_decompressor
    import lzmd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last
    output logic [1:0] m_tuser    // [1:0] status
);

    cmd_t cmd;
    sts_t sts;

    lzmd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    lzmd_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Error results carry a zero byte and close the run
    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != ST_OK)) |-> ((m_tdata == 8'h00) && m_tlast))
        else $error("error result with nonzero byte or open run");

    // No item is taken while a copy is reading history
    a_no_accept_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.copy_rd |-> !(s_tvalid && s_tready))
        else $error("item accepted during copy");

    // Each history read is followed by its write stage, not another read
    a_rd_wr_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.copy_rd |=> !cmd.copy_rd)
        else $error("back-to-back history reads");

    // A store and an error result never load the output together
    a_one_load: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.store && cmd.emit_err))
        else $error("store and error result in one cycle");

endmodule

// ===== rtl/core/lzmd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzmd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/lzmd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzmd_ctrl
// Controller: token parse phase, error latch and the copy sequencer.
// ----------------------------------------------------------------------------
module lzmd_ctrl
    import lzmd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic s_tlast,
    input  sts_t sts,
    output cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic        err_reg, err_next;
    logic        eos_pend_reg, eos_pend_next;
    logic        accept;

    // Take an item only when idle and the output slot can hold a result
    assign s_tready = (state_reg == CS_IDLE) && sts.out_free;
    assign accept   = s_tvalid && s_tready;

    // Next state
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        err_next      = err_reg;
        eos_pend_next = eos_pend_reg;
        unique case (state_reg)
            CS_IDLE: begin
                if (accept && !err_reg) begin
                    unique case (phase_reg)
                        PH_LIT: begin
                            if (sts.is_marker) begin
                                phase_next = PH_MARK;
                                if (s_tlast) begin
                                    err_next = 1'b1;
                                end
                            end
                        end
                        PH_MARK: begin
                            if (sts.is_zero) begin
                                phase_next = PH_LIT;
                            end else begin
                                phase_next = PH_MID;
                                if (s_tlast) begin
                                    err_next = 1'b1;
                                end
                            end
                        end
                        PH_MID: begin
                            phase_next = PH_LIT;
                            if (sts.too_far) begin
                                err_next = 1'b1;
                            end else begin
                                state_next    = CS_COPY_RD;
                                eos_pend_next = s_tlast;
                            end
                        end
                        default: begin
                            phase_next = PH_LIT;
                        end
                    endcase
                end
                // End of stream clears the parse state after the item
                if (accept && s_tlast) begin
                    phase_next = PH_LIT;
                    err_next   = 1'b0;
                end
            end
            CS_COPY_RD: begin
                state_next = CS_COPY_WR;
            end
            CS_COPY_WR: begin
                if (sts.out_free) begin
                    if (sts.copy_last) begin
                        state_next    = CS_IDLE;
                        eos_pend_next = 1'b0;
                    end else begin
                        state_next = CS_COPY_RD;
                    end
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd = '0;
        cmd.src      = SRC_INPUT;
        cmd.err_code = ST_OK;
        unique case (state_reg)
            CS_IDLE: begin
                if (accept && !err_reg) begin
                    unique case (phase_reg)
                        PH_LIT: begin
                            if (!sts.is_marker) begin
                                cmd.store = 1'b1;
                                cmd.src   = SRC_INPUT;
                            end else if (s_tlast) begin
                                cmd.emit_err = 1'b1;
                                cmd.err_code = ST_TRUNC_MARK;
                            end
                        end
                        PH_MARK: begin
                            cmd.hold_mid = 1'b1;
                            if (sts.is_zero) begin
                                cmd.store = 1'b1;
                                cmd.src   = SRC_MARK;
                            end else if (s_tlast) begin
                                cmd.emit_err = 1'b1;
                                cmd.err_code = ST_TRUNC_TOKEN;
                            end
                        end
                        PH_MID: begin
                            if (sts.too_far) begin
                                cmd.emit_err = 1'b1;
                                cmd.err_code = ST_DIST_FAR;
                            end else begin
                                cmd.start_copy = 1'b1;
                            end
                        end
                        default: begin
                            cmd.store = 1'b0;
                        end
                    endcase
                end
                // Clear now unless a copy still has to run
                cmd.clear = accept && s_tlast && !cmd.start_copy;
            end
            CS_COPY_RD: begin
                cmd.copy_rd = 1'b1;
            end
            CS_COPY_WR: begin
                if (sts.out_free) begin
                    cmd.store = 1'b1;
                    cmd.src   = SRC_HIST;
                    cmd.clear = sts.copy_last && eos_pend_reg;
                end
            end
            default: begin
                cmd.store = 1'b0;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= CS_IDLE;
            phase_reg    <= PH_LIT;
            err_reg      <= 1'b0;
            eos_pend_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            err_reg      <= err_next;
            eos_pend_reg <= eos_pend_next;
        end
    end

endmodule

// ===== rtl/core/lzmd_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzmd_dpath
// Datapath: history RAM, write pointer, produced count, copy length and
// distance, and the output register.
// ----------------------------------------------------------------------------
module lzmd_dpath
    import lzmd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_tdata,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic [1:0] m_tuser,
    input  cmd_t       cmd,
    output sts_t       sts
);

    localparam logic [HIST_AW-1:0] HIST_LAST  = HIST_AW'(HISTORY_DEPTH - 1);
    localparam logic [CALC_W-1:0]  DEPTH_EXT  = CALC_W'(HISTORY_DEPTH);

    logic [7:0]         mid_reg;
    logic [HIST_AW-1:0] wp_reg, wp_next;
    logic [11:0]        prod_reg, prod_next;
    logic [LEN_W-1:0]   rem_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic               out_valid_reg;
    logic [7:0]         out_data_reg;
    logic               out_last_reg;
    status_t            out_status_reg;

    logic [DIST_W-1:0]  dist_in;
    logic [LEN_W-1:0]   len_in;
    logic [CALC_W-1:0]  wp_ext, dist_ext, src_ext;
    logic [7:0]         hist_rdata;
    logic [7:0]         store_data;
    logic               store_last;

    // Token fields from held middle byte and current byte
    assign dist_in = {1'b0, mid_reg[2:0] & DIST_HI_MASK, s_tdata} + DIST_W'(1);
    assign len_in  = LEN_W'(mid_reg[7:3]) + LEN_BIAS;

    // Status to controller
    assign sts.is_marker = (s_tdata == MARK_BYTE);
    assign sts.is_zero   = (s_tdata == ZERO_BYTE);
    assign sts.too_far   = (dist_in > prod_reg);
    assign sts.copy_last = (rem_reg == LEN_W'(1));
    assign sts.out_free  = !out_valid_reg || m_tready;

    // Source address: write pointer minus distance, wrapped
    assign wp_ext   = CALC_W'(wp_reg);
    assign dist_ext = CALC_W'(dist_reg);
    assign src_ext  = (wp_ext >= dist_ext) ? (wp_ext - dist_ext)
                                           : (wp_ext + DEPTH_EXT - dist_ext);

    // Pick the byte to store and emit
    always_comb begin
        case (cmd.src)
            SRC_INPUT: begin
                store_data = s_tdata;
                store_last = 1'b1;
            end
            SRC_MARK: begin
                store_data = MARK_BYTE;
                store_last = 1'b1;
            end
            SRC_HIST: begin
                store_data = hist_rdata;
                store_last = sts.copy_last;
            end
            default: begin
                store_data = s_tdata;
                store_last = 1'b1;
            end
        endcase
    end

    lzmd_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .aclk  (aclk),
        .we    (cmd.store),
        .waddr (wp_reg),
        .wdata (store_data),
        .re    (cmd.copy_rd),
        .raddr (src_ext[HIST_AW-1:0]),
        .rdata (hist_rdata)
    );

    // Advance pointer and saturating count; end of stream wins
    always_comb begin
        wp_next   = wp_reg;
        prod_next = prod_reg;
        if (cmd.store) begin
            wp_next = (wp_reg == HIST_LAST) ? '0 : wp_reg + HIST_AW'(1);
            if (prod_reg < MAX_REACH) begin
                prod_next = prod_reg + 12'd1;
            end
        end
        if (cmd.clear) begin
            wp_next   = '0;
            prod_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            prod_reg <= '0;
            mid_reg  <= '0;
        end else begin
            wp_reg   <= wp_next;
            prod_reg <= prod_next;
            if (cmd.hold_mid) begin
                mid_reg <= s_tdata;
            end
        end
    end

    // Copy length and distance
    always_ff @(posedge aclk) begin
        if (cmd.start_copy) begin
            rem_reg  <= len_in;
            dist_reg <= dist_in;
        end else if (cmd.store && (cmd.src == SRC_HIST)) begin
            rem_reg <= rem_reg - LEN_W'(1);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.store || cmd.emit_err) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_err) begin
            out_data_reg   <= '0;
            out_last_reg   <= 1'b1;
            out_status_reg <= cmd.err_code;
        end else if (cmd.store) begin
            out_data_reg   <= store_data;
            out_last_reg   <= store_last;
            out_status_reg <= ST_OK;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

endmodule
